### rtl/lz4_block_decompressor_core_defines.svh
// Assertion macros used by the LZ4 decompressor top level.
`ifndef LZ4_BLOCK_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LZ4D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define LZ4D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lz4d_pkg.sv
// Shared types and constants of the LZ4 block decompressor.
package lz4d_pkg;

  localparam logic       REQ_BYTE  = 1'b0;
  localparam logic       REQ_PULL  = 1'b1;

  localparam logic [3:0] NIB_MAX   = 4'd15;
  localparam logic [7:0] EXT_RUN   = 8'd255;
  localparam logic [7:0] MIN_MATCH = 8'd4;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_TRUNC = 3'd1;
  localparam logic [2:0] ERR_ZERO  = 3'd2;
  localparam logic [2:0] ERR_FAR   = 3'd3;
  localparam logic [2:0] ERR_CAP   = 3'd4;

  localparam logic [23:0] CAP_RESET = 24'hFFFFFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        copy_pending;
    logic        done_res;
    logic [2:0]  error_code;
    logic [23:0] out_total;
  } out_item_t;

  // Per-item result of the parser, before the history byte is known.
  typedef struct packed {
    logic        accepted;
    logic        emit;
    logic        from_hist;
    logic        use_fwd;
    logic [7:0]  lit_byte;
    logic        copy_pending;
    logic        done_res;
    logic [2:0]  error_code;
    logic [23:0] out_total;
  } step_t;

endpackage

### rtl/lz4d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lz4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lz4d_parser.sv
// LZ4 block grammar state, counters, error checks and history pointers.
module lz4d_parser #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int COUNT_WIDTH   = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [23:0]                      cfg_data,
  input  logic                             step_en,
  input  lz4d_pkg::in_item_t               item,
  output lz4d_pkg::step_t                  step,
  output logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
  output logic [$clog2(HISTORY_DEPTH)-1:0] waddr
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CW   = COUNT_WIDTH;
  localparam int OW   = ((AW > 16) ? AW : 16) + 1;
  localparam int CMPW = ((CW > 24) ? CW : 24) + 1;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LIT_EXT,
    PH_LIT,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATCH_EXT,
    PH_COPY
  } phase_t;

  function automatic logic [CW-1:0] cap_clip(input logic [23:0] v);
    if (CMPW'(v) > CMPW'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [8:0] b);
    logic [CW:0] sum;
    sum = (CW+1)'(a) + (CW+1)'(b);
    return sum[CW] ? CNT_MAX : sum[CW-1:0];
  endfunction

  phase_t        phase, phase_next;
  logic [3:0]    nibble, nibble_next;
  logic [CW-1:0] lit_rem, lit_rem_next;
  logic [CW-1:0] m_rem, m_rem_next;
  logic [15:0]   off, off_next;
  logic [CW-1:0] produced, produced_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [2:0]    err, err_next;
  logic          fin, fin_next;
  logic [CW-1:0] cap_lim;

  logic [7:0]    b;
  logic [3:0]    hi;
  logic [CW-1:0] lit_ext, m_ext, m_fin, m_short, chk_len;
  logic [15:0]   off_new, off_chk;
  logic          cap_bad, far_bad;
  logic [OW-1:0] diff;
  logic [AW-1:0] rd_start, wr_inc, rd_inc;

  assign b       = item.in_byte;
  assign hi      = b[7:4];
  assign lit_ext = sat_add(lit_rem, {1'b0, b});
  assign m_ext   = sat_add(m_rem, {1'b0, b});
  assign m_fin   = sat_add(m_rem, 9'(b) + 9'(lz4d_pkg::MIN_MATCH));
  assign m_short = CW'(nibble) + CW'(lz4d_pkg::MIN_MATCH);
  assign off_new = {b, off[7:0]};
  assign off_chk = (phase == PH_OFF_HI) ? off_new : off;

  // One length check serves both literal and match runs.
  always_comb begin
    if (phase == PH_TOKEN) begin
      chk_len = CW'(hi);
    end else if (phase == PH_LIT_EXT) begin
      chk_len = lit_ext;
    end else if (phase == PH_OFF_HI) begin
      chk_len = m_short;
    end else begin
      chk_len = m_fin;
    end
  end

  assign cap_bad = (chk_len == CNT_MAX) ||
                   ((CW+1)'(produced) + (CW+1)'(chk_len) > (CW+1)'(cap_lim));
  assign far_bad = (CW'(off_chk) > produced) ||
                   (17'(off_chk) > 17'(HISTORY_DEPTH));

  // Copy source: write pointer minus offset, wrapped into the history.
  assign diff     = OW'(wr_ptr) - OW'(off_chk);
  assign rd_start = diff[OW-1] ? AW'(diff + OW'(HISTORY_DEPTH)) : AW'(diff);
  assign wr_inc   = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_inc   = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;

  assign raddr = rd_ptr;
  assign waddr = wr_ptr;

  always_comb begin
    phase_next    = phase;
    nibble_next   = nibble;
    lit_rem_next  = lit_rem;
    m_rem_next    = m_rem;
    off_next      = off;
    produced_next = produced;
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    err_next      = err;
    fin_next      = fin;
    step          = '0;

    if (item.req_type == lz4d_pkg::REQ_BYTE) begin
      if (err == lz4d_pkg::ERR_NONE && !fin && phase != PH_COPY) begin
        step.accepted = 1'b1;
        unique case (phase)
          PH_TOKEN: begin
            nibble_next  = b[3:0];
            lit_rem_next = CW'(hi);
            if (hi == lz4d_pkg::NIB_MAX) begin
              phase_next = PH_LIT_EXT;
            end else if (cap_bad) begin
              err_next = lz4d_pkg::ERR_CAP;
            end else begin
              phase_next = (hi != 4'd0) ? PH_LIT : PH_OFF_LO;
            end
          end
          PH_LIT_EXT: begin
            lit_rem_next = lit_ext;
            if (b != lz4d_pkg::EXT_RUN) begin
              if (cap_bad) begin
                err_next = lz4d_pkg::ERR_CAP;
              end else begin
                phase_next = (lit_ext != '0) ? PH_LIT : PH_OFF_LO;
              end
            end
          end
          PH_LIT: begin
            step.emit     = 1'b1;
            step.lit_byte = b;
            produced_next = produced + 1'b1;
            wr_ptr_next   = wr_inc;
            lit_rem_next  = lit_rem - 1'b1;
            if (lit_rem == CW'(1)) begin
              phase_next = PH_OFF_LO;
            end
          end
          PH_OFF_LO: begin
            off_next   = {8'h00, b};
            phase_next = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            off_next = off_new;
            if (off_new == 16'd0) begin
              err_next = lz4d_pkg::ERR_ZERO;
            end else if (nibble == lz4d_pkg::NIB_MAX) begin
              m_rem_next = CW'(lz4d_pkg::NIB_MAX);
              phase_next = PH_MATCH_EXT;
            end else begin
              m_rem_next = m_short;
              if (far_bad) begin
                err_next = lz4d_pkg::ERR_FAR;
              end else if (cap_bad) begin
                err_next = lz4d_pkg::ERR_CAP;
              end else begin
                phase_next  = PH_COPY;
                rd_ptr_next = rd_start;
              end
            end
          end
          PH_MATCH_EXT: begin
            if (b != lz4d_pkg::EXT_RUN) begin
              m_rem_next = m_fin;
              if (far_bad) begin
                err_next = lz4d_pkg::ERR_FAR;
              end else if (cap_bad) begin
                err_next = lz4d_pkg::ERR_CAP;
              end else begin
                phase_next  = PH_COPY;
                rd_ptr_next = rd_start;
              end
            end else begin
              m_rem_next = m_ext;
            end
          end
          default: begin
          end
        endcase
        // A block may only end after literals or after a match header.
        if (item.in_last && err_next == lz4d_pkg::ERR_NONE) begin
          if (phase_next == PH_OFF_LO || phase_next == PH_COPY) begin
            fin_next = 1'b1;
          end else begin
            err_next = lz4d_pkg::ERR_TRUNC;
          end
        end
      end
    end else if (err == lz4d_pkg::ERR_NONE && phase == PH_COPY) begin
      step.emit      = 1'b1;
      step.from_hist = 1'b1;
      step.use_fwd   = (off == 16'd1);
      produced_next  = produced + 1'b1;
      wr_ptr_next    = wr_inc;
      rd_ptr_next    = rd_inc;
      m_rem_next     = m_rem - 1'b1;
      if (m_rem == CW'(1)) begin
        phase_next = PH_TOKEN;
      end
    end

    step.copy_pending = (err_next == lz4d_pkg::ERR_NONE) && (phase_next == PH_COPY);
    step.done_res     = (err_next == lz4d_pkg::ERR_NONE) && fin_next &&
                        (phase_next != PH_COPY);
    step.error_code   = err_next;
    step.out_total    = 24'(produced_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TOKEN;
      nibble   <= '0;
      lit_rem  <= '0;
      m_rem    <= '0;
      off      <= '0;
      produced <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      err      <= lz4d_pkg::ERR_NONE;
      fin      <= 1'b0;
      cap_lim  <= cap_clip(lz4d_pkg::CAP_RESET);
    end else begin
      if (cfg_we) begin
        cap_lim <= cap_clip(cfg_data);
      end
      if (step_en) begin
        phase    <= phase_next;
        nibble   <= nibble_next;
        lit_rem  <= lit_rem_next;
        m_rem    <= m_rem_next;
        off      <= off_next;
        produced <= produced_next;
        wr_ptr   <= wr_ptr_next;
        rd_ptr   <= rd_ptr_next;
        err      <= err_next;
        fin      <= fin_next;
      end
    end
  end

endmodule

### rtl/lz4_block_decompressor_core.sv
// LZ4 block decompressor top level: handshake stages, history RAM, result register.
//
// Usage:
//   in_*  : one item per handshake, either a compressed byte (req_type 0) or
//           a pull of the next match byte (req_type 1). Every item gives one
//           result item on res_*.
//   cfg_* : writes output_capacity; take it only while the block is idle.
//   res_* : accepted flag, decompressed byte, copy/done status, sticky error
//           code and running output count.
// Path: an accepted item is registered in the middle stage, then moves
//   into the output register once that register is free or being read.
// Throughput: one item per cycle while res_ready stays high; the history
//   RAM has one write and one registered read port, and an offset of one
//   is served from a bypass register of the last byte produced.
// Reset: parser returns to expect-token, counters and errors clear, output
//   capacity returns to its maximum. The history RAM is not cleared.
// Stall: when res_ready is low the result holds, the middle stage fills and
//   then in_ready drops; no item is lost or repeated.
`include "lz4_block_decompressor_core_defines.svh"

module lz4_block_decompressor_core #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int COUNT_WIDTH   = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lz4d_pkg::in_item_t  in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output lz4d_pkg::out_item_t res_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic            in_accept;
  logic            s1_valid;
  logic            s1_adv;
  lz4d_pkg::step_t step;
  lz4d_pkg::step_t s1_step;
  logic [AW-1:0]   raddr, waddr, s1_waddr;
  logic [7:0]      ram_rdata;
  logic [7:0]      last_byte;
  logic [7:0]      s1_byte;
  logic            ram_we;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!res_valid || res_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  lz4d_parser #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .step_en (in_accept),
    .item    (in_data),
    .step    (step),
    .raddr   (raddr),
    .waddr   (waddr)
  );

  // Offset one reads the byte just produced, which may still be on its way
  // into the RAM.
  always_comb begin
    if (!s1_step.emit) begin
      s1_byte = 8'h00;
    end else if (!s1_step.from_hist) begin
      s1_byte = s1_step.lit_byte;
    end else if (s1_step.use_fwd) begin
      s1_byte = last_byte;
    end else begin
      s1_byte = ram_rdata;
    end
  end

  assign ram_we = s1_adv && s1_step.emit;

  lz4d_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_waddr),
    .wdata(s1_byte),
    .re   (in_accept && step.from_hist),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_step  <= step;
      s1_waddr <= waddr;
    end
    if (ram_we) begin
      last_byte <= s1_byte;
    end
    if (s1_adv) begin
      res_data.accepted     <= s1_step.accepted;
      res_data.out_valid    <= s1_step.emit;
      res_data.out_byte     <= s1_byte;
      res_data.copy_pending <= s1_step.copy_pending;
      res_data.done_res     <= s1_step.done_res;
      res_data.error_code   <= s1_step.error_code;
      res_data.out_total    <= s1_step.out_total;
    end
  end

  `LZ4D_ASSERT_IMP(a_pending_not_done, res_valid,
                   !(res_data.copy_pending && res_data.done_res),
                   "copy pending and done both set")
  `LZ4D_ASSERT_NEXT(a_hist_read_lands, in_accept && step.from_hist,
                    s1_valid && s1_step.from_hist,
                    "history read without matching stage item")
  `LZ4D_ASSERT_NEXT(a_error_sticky,
                    s1_adv && s1_step.error_code != lz4d_pkg::ERR_NONE,
                    !s1_valid || s1_step.error_code == $past(s1_step.error_code),
                    "error code changed after being set")
  `LZ4D_ASSERT_IMP(a_fwd_only_copy, s1_valid && s1_step.use_fwd,
                   s1_step.from_hist && s1_step.emit,
                   "bypass selected for an item that is not a copy")

endmodule

### tb/sv/lz4_block_decompressor_core_checker.sv
// Channel monitor for the LZ4 decompressor: predicts every result item and compares it.
module lz4_block_decompressor_core_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lz4d_pkg::in_item_t  in_data,
  input  logic                res_valid,
  input  logic                res_ready,
  input  lz4d_pkg::out_item_t res_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [23:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  typedef enum logic [2:0] {
    P_TOKEN, P_LIT_EXT, P_LIT, P_OFF_LO, P_OFF_HI, P_MATCH_EXT, P_COPY
  } phase_t;

  phase_t      phase;
  logic [3:0]  match_nib;
  logic [23:0] lit_left;
  logic [23:0] match_left;
  logic [15:0] back_off;
  logic [23:0] made_count;
  logic [23:0] cap_limit;
  logic [2:0]  err_code;
  logic        done_flag;
  logic [7:0]  hist [0:65535];

  lz4d_pkg::out_item_t decoded_q[$];
  lz4d_pkg::out_item_t want_item;
  int                  res_index;

  initial begin
    fail_count = 0;
    pending = 0;
    res_index = 0;
  end

  function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [7:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] result item %0d: %s", $time, res_index, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic store_byte(input logic [7:0] b);
    hist[made_count[15:0]] = b;
    made_count = made_count + 24'd1;
  endtask

  // Capacity is checked on the whole run before any byte of it goes out.
  task automatic start_literals();
    if (lit_left == 24'hFFFFFF ||
        ({1'b0, made_count} + {1'b0, lit_left}) > {1'b0, cap_limit})
      err_code = lz4d_pkg::ERR_CAP;
    else
      phase = (lit_left != 24'd0) ? P_LIT : P_OFF_LO;
  endtask

  task automatic start_copy();
    if ({8'd0, back_off} > made_count)
      err_code = lz4d_pkg::ERR_FAR;
    else if (match_left == 24'hFFFFFF ||
             ({1'b0, made_count} + {1'b0, match_left}) > {1'b0, cap_limit})
      err_code = lz4d_pkg::ERR_CAP;
    else
      phase = P_COPY;
  endtask

  task automatic decode_item(input lz4d_pkg::in_item_t it, output lz4d_pkg::out_item_t r);
    logic [7:0]  b;
    logic [7:0]  ob;
    logic        emit;
    logic [15:0] src;
    r = '0;
    b = it.in_byte;
    ob = 8'd0;
    emit = 1'b0;
    if (it.req_type == lz4d_pkg::REQ_BYTE) begin
      if (err_code == lz4d_pkg::ERR_NONE && !done_flag && phase != P_COPY) begin
        r.accepted = 1'b1;
        case (phase)
          P_TOKEN: begin
            match_nib = b[3:0];
            lit_left = {20'd0, b[7:4]};
            if (b[7:4] == lz4d_pkg::NIB_MAX) phase = P_LIT_EXT;
            else start_literals();
          end
          P_LIT_EXT: begin
            lit_left = sat_add(lit_left, b);
            if (b != lz4d_pkg::EXT_RUN) start_literals();
          end
          P_LIT: begin
            ob = b;
            emit = 1'b1;
            store_byte(b);
            lit_left = lit_left - 24'd1;
            if (lit_left == 24'd0) phase = P_OFF_LO;
          end
          P_OFF_LO: begin
            back_off = {8'd0, b};
            phase = P_OFF_HI;
          end
          P_OFF_HI: begin
            back_off[15:8] = b;
            if (back_off == 16'd0) begin
              err_code = lz4d_pkg::ERR_ZERO;
            end else if (match_nib == lz4d_pkg::NIB_MAX) begin
              match_left = {20'd0, lz4d_pkg::NIB_MAX};
              phase = P_MATCH_EXT;
            end else begin
              match_left = {20'd0, match_nib} + {16'd0, lz4d_pkg::MIN_MATCH};
              start_copy();
            end
          end
          P_MATCH_EXT: begin
            match_left = sat_add(match_left, b);
            if (b != lz4d_pkg::EXT_RUN) begin
              match_left = sat_add(match_left, lz4d_pkg::MIN_MATCH);
              start_copy();
            end
          end
          default: ;
        endcase
        // end of block is legal only between sequences or with a copy armed
        if (it.in_last && err_code == lz4d_pkg::ERR_NONE) begin
          if (phase == P_OFF_LO || phase == P_COPY) done_flag = 1'b1;
          else err_code = lz4d_pkg::ERR_TRUNC;
        end
      end
    end else if (err_code == lz4d_pkg::ERR_NONE && phase == P_COPY) begin
      src = made_count[15:0] - back_off;
      ob = hist[src];
      emit = 1'b1;
      store_byte(ob);
      match_left = match_left - 24'd1;
      if (match_left == 24'd0) phase = P_TOKEN;
    end
    r.out_valid = emit;
    r.out_byte = emit ? ob : 8'd0;
    r.copy_pending = (err_code == lz4d_pkg::ERR_NONE && phase == P_COPY);
    r.done_res = (err_code == lz4d_pkg::ERR_NONE && done_flag && phase != P_COPY);
    r.error_code = err_code;
    r.out_total = made_count;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = P_TOKEN;
      match_nib = 4'd0;
      lit_left = 24'd0;
      match_left = 24'd0;
      back_off = 16'd0;
      made_count = 24'd0;
      cap_limit = lz4d_pkg::CAP_RESET;
      err_code = lz4d_pkg::ERR_NONE;
      done_flag = 1'b0;
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_limit = cfg_data;
      if (res_valid && res_ready) begin
        if (decoded_q.size() == 0) begin
          note_mismatch("result with no item outstanding");
        end else begin
          want_item = decoded_q.pop_front();
          check_field("accepted", res_data.accepted, want_item.accepted);
          check_field("out_valid", res_data.out_valid, want_item.out_valid);
          check_field("out_byte", res_data.out_byte, want_item.out_byte);
          check_field("copy_pending", res_data.copy_pending, want_item.copy_pending);
          check_field("done_res", res_data.done_res, want_item.done_res);
          check_field("error_code", res_data.error_code, want_item.error_code);
          check_field("out_total", res_data.out_total, want_item.out_total);
        end
        res_index++;
      end
      if (in_valid && in_ready) begin
        decode_item(in_data, want_item);
        decoded_q.push_back(want_item);
      end
    end
    pending = decoded_q.size();
  end

endmodule

### tb/sv/lz4_block_decompressor_core_tb.sv
// Testbench top for the LZ4 decompressor: clock, reset, stimulus, back-pressure, verdict.
module lz4_block_decompressor_core_tb;

  localparam int CYCLE_LIMIT = 200_000;

  typedef enum int {
    END_LITERALS, END_HEADER, END_TRUNC, END_ZERO_OFF, END_FAR_OFF, END_CAPACITY
  } ending_t;

  typedef enum int {FLOW, CHOPPY, HOLD} stall_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  lz4d_pkg::in_item_t  in_data;
  logic                res_valid;
  logic                res_ready;
  lz4d_pkg::out_item_t res_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [23:0]         cfg_data;

  int          fail_count;
  int          pending;
  int          cycle_count;
  int          burst_left;
  int          item_count;
  int          phase_items;
  int unsigned bytes_made;
  logic [7:0]  stream_q[$];
  bit          legal_end_q[$];
  ending_t     ending;

  lz4_block_decompressor_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lz4_block_decompressor_core_checker lz4_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lz4_block_decompressor_core: mismatch");
    $finish;
  end

  // Result side: free-flowing, choppy and fully stalled stretches.
  initial begin
    stall_t mode;
    int     span;
    res_ready = 1'b0;
    mode = FLOW;
    span = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = stall_t'($urandom_range(0, 2));
        span = (mode == HOLD) ? $urandom_range(1, 8) : $urandom_range(1, 64);
      end
      span--;
      case (mode)
        FLOW:    res_ready <= 1'b1;
        CHOPPY:  res_ready <= 1'($urandom_range(0, 1));
        default: res_ready <= 1'b0;
      endcase
    end
  end

  // Called and returns at a falling edge; valid stays up between items of a burst.
  task automatic send_item(input logic req, input logic [7:0] b, input logic last);
    lz4d_pkg::in_item_t it;
    int                 gap;
    it.req_type = req;
    it.in_byte = b;
    it.in_last = last;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cap(input logic [23:0] v);
    go_idle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Copy pulls, with the odd byte offered mid-copy (refused, in_last ignored).
  task automatic pull_copy(input int n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        send_item(lz4d_pkg::REQ_BYTE, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      send_item(lz4d_pkg::REQ_PULL, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic push_length(input int extra);
    while (extra >= 255) begin
      stream_q.push_back(lz4d_pkg::EXT_RUN);
      legal_end_q.push_back(1'b0);
      extra -= 255;
    end
    stream_q.push_back(extra[7:0]);
    legal_end_q.push_back(1'b0);
  endtask

  // One well-formed sequence; legal_end_q marks bytes after which the block may end.
  task automatic build_seq(input int lit_len, input int mlen, input logic [15:0] off);
    int         lit_nib;
    int         m_nib;
    logic [7:0] lit_byte;
    lit_nib = (lit_len >= 15) ? 15 : lit_len;
    m_nib = (mlen - 4 >= 15) ? 15 : mlen - 4;
    stream_q.delete();
    legal_end_q.delete();
    stream_q.push_back({lit_nib[3:0], m_nib[3:0]});
    legal_end_q.push_back(lit_len == 0);
    if (lit_len >= 15) push_length(lit_len - 15);
    for (int i = 0; i < lit_len; i++) begin
      case ($urandom_range(0, 7))
        0:       lit_byte = 8'h00;
        1:       lit_byte = 8'hFF;
        default: lit_byte = 8'($urandom_range(0, 255));
      endcase
      stream_q.push_back(lit_byte);
      legal_end_q.push_back(i == lit_len - 1);
    end
    stream_q.push_back(off[7:0]);
    legal_end_q.push_back(1'b0);
    stream_q.push_back(off[15:8]);
    legal_end_q.push_back(m_nib != 15);
    if (m_nib == 15) begin
      push_length(mlen - 19);
      legal_end_q[legal_end_q.size() - 1] = 1'b1;
    end
  endtask

  task automatic send_seq(input int last_pos, input int n_pulls);
    for (int i = 0; i < stream_q.size(); i++)
      send_item(lz4d_pkg::REQ_BYTE, stream_q[i], i == last_pos);
    pull_copy(n_pulls);
  endtask

  // Mostly short runs, some needing an extension byte, a few past a 255 run.
  function automatic int draw_length(input int base);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return base + 15 + $urandom_range(255, 545);
    if (pick < 6) return base + 15 + $urandom_range(0, 40);
    return base + $urandom_range(0, 14);
  endfunction

  function automatic logic [15:0] draw_offset(input int p);
    int lim;
    lim = (p > 65535) ? 65535 : p;
    if ($urandom_range(0, 1) == 1) return 16'($urandom_range(1, (lim < 8) ? lim : 8));
    return 16'($urandom_range(1, lim));
  endfunction

  initial begin
    int          lit_len;
    int          mlen;
    int          last_pos;
    int          p;
    logic [15:0] off;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 24'd0;
    burst_left = 0;
    bytes_made = 0;
    item_count = 0;
    phase_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle pulls under zero capacity, then a literal pair and an offset-one overlap copy
    write_cap(24'd0);
    send_item(lz4d_pkg::REQ_PULL, 8'hFF, 1'b1);
    send_item(lz4d_pkg::REQ_PULL, 8'h00, 1'b0);
    write_cap(lz4d_pkg::CAP_RESET);
    build_seq(2, 4, 16'd1);
    stream_q[1] = 8'h00;
    stream_q[2] = 8'hFF;
    send_seq(-1, 0);
    send_item(lz4d_pkg::REQ_BYTE, 8'h5A, 1'b1);
    pull_copy(4);
    send_item(lz4d_pkg::REQ_PULL, 8'h00, 1'b1);
    // no literals, offset reaching back to the very first byte
    build_seq(0, 5, 16'd6);
    send_seq(-1, 5);
    bytes_made = 11;

    while (item_count < 1050) begin
      if (phase_items >= 150) begin
        write_cap(($urandom_range(0, 3) == 0) ? lz4d_pkg::CAP_RESET :
                  24'($urandom_range(bytes_made + 4000, lz4d_pkg::CAP_RESET)));
        phase_items = 0;
      end
      lit_len = draw_length(0);
      mlen = draw_length(4);
      off = draw_offset(bytes_made + lit_len);
      build_seq(lit_len, mlen, off);
      send_seq(-1, mlen);
      bytes_made += lit_len + mlen;
      phase_items += stream_q.size() + mlen;
      item_count += stream_q.size() + mlen;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_item(lz4d_pkg::REQ_PULL, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
    end

    // errors and the end flag are sticky, so each run closes the block one way
    ending = ending_t'($urandom_range(0, 5));
    lit_len = (ending == END_LITERALS) ? $urandom_range(0, 4) : draw_length(0);
    mlen = draw_length(4);
    p = bytes_made + lit_len;
    off = draw_offset(p);
    last_pos = -1;
    case (ending)
      END_ZERO_OFF: off = 16'd0;
      END_FAR_OFF:  off = (p < 65535) ? 16'(p + 1) : 16'd0;
      END_CAPACITY: write_cap(24'(p + mlen - 1));
      default: ;
    endcase
    build_seq(lit_len, mlen, off);
    if (ending == END_LITERALS) begin
      last_pos = 0;
      while (!legal_end_q[last_pos]) last_pos++;
    end else if (ending == END_HEADER) begin
      last_pos = stream_q.size() - 1;
    end else if (ending == END_TRUNC) begin
      do last_pos = $urandom_range(0, stream_q.size() - 1);
      while (legal_end_q[last_pos]);
    end
    send_seq(last_pos, mlen);
    // all of this is refused or yields nothing
    repeat (24) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));

    go_idle();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("lz4_block_decompressor_core: match");
    else
      $display("lz4_block_decompressor_core: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lz4d_pkg.sv
rtl/lz4d_ram.sv
rtl/lz4d_parser.sv
rtl/lz4_block_decompressor_core.sv
tb/sv/lz4_block_decompressor_core_checker.sv
tb/sv/lz4_block_decompressor_core_tb.sv
